// ----- sv/tfb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the telemetry frame builder.
// No dependencies; the front end, the serializer and the top level import this package.
package tfb_pkg;

  // Largest frame, header through checksum, that is accepted.
  localparam int TFB_FRAME_BYTES_MAX = 32;

  // Depths of the job queue and the result queue.
  localparam int TFB_JOB_Q_DEPTH = 2;
  localparam int TFB_RES_Q_DEPTH = 2;

  // Register reset values.
  localparam logic [7:0] TFB_SYNC_RESET = 8'hAA;
  localparam logic [7:0] TFB_FUNC_RESET = 8'hF1;

  // Input action codes.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_VALUE = 1'b1;

  // Data bytes carried by each kind of job.
  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [2:0] HALF_BYTES = 3'd2;

  typedef enum logic [1:0] {
    JOB_HEADER,
    JOB_WORD,
    JOB_HALF,
    JOB_REJECT
  } job_kind_t;

  // One unit of work for the serializer: up to four bytes, left aligned.
  typedef struct packed {
    job_kind_t   kind;
    logic        close;
    logic [31:0] data;
  } job_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       status;
  } res_t;

endpackage

// ----- sv/tfb_fifo.sv -----
`timescale 1ns / 1ps
// Small synchronous queue used between the front end and the serializer and
// for the results. Independent of the package; the item type is a parameter.
module tfb_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic  [AW-1:0] wr_ptr;
  logic  [AW-1:0] rd_ptr;
  logic  [CW-1:0] count;
  logic           do_wr;
  logic           do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/tfb_front.sv -----
`timescale 1ns / 1ps
// Front end: takes input items, tracks the open frame and turns each start item,
// and each value item that the open frame expects, into one serializer job. Depends on tfb_pkg.
module tfb_front #(
  parameter int FRAME_BYTES_MAX = tfb_pkg::TFB_FRAME_BYTES_MAX
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          action,
  input  logic [3:0]    float_count,
  input  logic [3:0]    wide_int_count,
  input  logic [3:0]    narrow_int_count,
  input  logic [31:0]   value_bits,
  input  logic [7:0]    sync_byte,
  input  logic [7:0]    function_id,
  output logic          job_push,
  output tfb_pkg::job_t job
);
  import tfb_pkg::*;

  localparam logic [8:0] LIMIT = 9'(FRAME_BYTES_MAX);

  logic [4:0] wide_values_left;
  logic [3:0] narrow_values_left;
  logic       frame_open;
  logic [4:0] wide_values_left_next;
  logic [3:0] narrow_values_left_next;
  logic       frame_open_next;

  logic [4:0] wide_sum;
  logic [7:0] payload_len;
  logic [8:0] total_len;

  assign wide_sum    = {1'b0, float_count} + {1'b0, wide_int_count};
  assign payload_len = {1'b0, wide_sum, 2'b00} + {3'b000, narrow_int_count, 1'b0};
  assign total_len   = {1'b0, payload_len} + 9'd5;

  always_comb begin
    wide_values_left_next   = wide_values_left;
    narrow_values_left_next = narrow_values_left;
    frame_open_next         = frame_open;
    job_push                = 1'b0;
    job.kind                = JOB_WORD;
    job.close               = 1'b0;
    job.data                = value_bits;

    if (accept) begin
      if (action == ACT_START) begin
        job_push                = 1'b1;
        wide_values_left_next   = '0;
        narrow_values_left_next = '0;
        frame_open_next         = 1'b0;
        if (total_len > LIMIT) begin
          job.kind = JOB_REJECT;
        end else begin
          job.kind  = JOB_HEADER;
          job.data  = {sync_byte, sync_byte, function_id, payload_len};
          // An empty frame closes right after its header.
          job.close = (wide_sum == '0) && (narrow_int_count == '0);
          wide_values_left_next   = wide_sum;
          narrow_values_left_next = narrow_int_count;
          frame_open_next         = !job.close;
        end
      end else if (frame_open) begin
        if (wide_values_left != '0) begin
          job_push              = 1'b1;
          job.kind              = JOB_WORD;
          job.close             = (wide_values_left == 5'd1) && (narrow_values_left == '0);
          wide_values_left_next = wide_values_left - 1'b1;
          frame_open_next       = !job.close;
        end else if (narrow_values_left != '0) begin
          job_push                = 1'b1;
          job.kind                = JOB_HALF;
          job.data                = {value_bits[15:0], 16'h0000};
          job.close               = (narrow_values_left == 4'd1);
          narrow_values_left_next = narrow_values_left - 1'b1;
          frame_open_next         = !job.close;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_values_left   <= '0;
      narrow_values_left <= '0;
      frame_open         <= 1'b0;
    end else begin
      wide_values_left   <= wide_values_left_next;
      narrow_values_left <= narrow_values_left_next;
      frame_open         <= frame_open_next;
    end
  end

endmodule

// ----- sv/tfb_back.sv -----
`timescale 1ns / 1ps
// Serializer: carries out jobs one byte per cycle while the result queue has room,
// keeps the running sum and appends the checksum byte. Depends on tfb_pkg.
module tfb_back (
  input  logic          clk,
  input  logic          rst,
  input  tfb_pkg::job_t job,
  input  logic          job_empty,
  output logic          job_pop,
  output tfb_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full
);
  import tfb_pkg::*;

  logic [31:0] shift;
  logic [2:0]  bytes_left;
  logic        close_pend;
  logic        reject_pend;
  logic [7:0]  running_sum;
  logic [31:0] shift_next;
  logic [2:0]  bytes_left_next;
  logic        close_pend_next;
  logic        reject_pend_next;
  logic [7:0]  running_sum_next;

  logic busy;
  logic emit;
  logic final_byte;
  logic load;

  assign busy       = (bytes_left != '0) || close_pend || reject_pend;
  assign emit       = busy && !res_full;
  assign final_byte = reject_pend || ((bytes_left == 3'd1) && !close_pend)
                      || ((bytes_left == '0) && close_pend);
  // The next job is loaded in the cycle that the current one sends its final byte.
  assign load       = !job_empty && (!busy || (emit && final_byte));
  assign job_pop    = load;
  assign res_push   = emit;

  always_comb begin
    if (reject_pend) begin
      res = '{frame_byte: 8'h00, last_byte: 1'b0, status: 1'b1};
    end else if (bytes_left != '0) begin
      res = '{frame_byte: shift[31:24], last_byte: 1'b0, status: 1'b0};
    end else begin
      res = '{frame_byte: running_sum, last_byte: 1'b1, status: 1'b0};
    end
  end

  always_comb begin
    shift_next       = shift;
    bytes_left_next  = bytes_left;
    close_pend_next  = close_pend;
    reject_pend_next = reject_pend;
    running_sum_next = running_sum;

    if (emit) begin
      if (reject_pend) begin
        reject_pend_next = 1'b0;
      end else if (bytes_left != '0) begin
        shift_next       = {shift[23:0], 8'h00};
        bytes_left_next  = bytes_left - 1'b1;
        running_sum_next = running_sum + shift[31:24];
      end else begin
        close_pend_next  = 1'b0;
        running_sum_next = '0;
      end
    end

    if (load) begin
      shift_next       = job.data;
      close_pend_next  = job.close;
      reject_pend_next = (job.kind == JOB_REJECT);
      case (job.kind)
        JOB_HEADER: bytes_left_next = WORD_BYTES;
        JOB_WORD:   bytes_left_next = WORD_BYTES;
        JOB_HALF:   bytes_left_next = HALF_BYTES;
        default:    bytes_left_next = '0;
      endcase
      // A start drops whatever frame was open, so the sum begins again.
      if (job.kind == JOB_HEADER || job.kind == JOB_REJECT) begin
        running_sum_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift <= shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= '0;
      close_pend  <= 1'b0;
      reject_pend <= 1'b0;
      running_sum <= '0;
    end else begin
      bytes_left  <= bytes_left_next;
      close_pend  <= close_pend_next;
      reject_pend <= reject_pend_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

// ----- sv/telemetry_frame_builder.sv -----
`timescale 1ns / 1ps
// Top level of the telemetry frame builder: configuration registers, front end,
// job queue, serializer and result queue. Depends on tfb_pkg and all tfb_ modules.
//
//  Channel   Handshake                       Payload
//  input     push / full                     action, float_count, wide_int_count,
//                                            narrow_int_count, value_bits
//  result    empty / pop                     frame_byte, last_byte, status
//  config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// The serializer sends one byte per cycle while the result queue has room: a start
// item gives 4 bytes (1 if rejected), a 32-bit value 4, a 16-bit value 2, checksum 1.
// The front end takes an item in any cycle the two-entry job queue has room.
// Reset is synchronous and clears all control state; registers return to
// sync 0xAA and function id 0xF1. A stalled pop holds the serializer only once
// the result queue has filled.
module telemetry_frame_builder #(
  parameter int FRAME_BYTES_MAX = tfb_pkg::TFB_FRAME_BYTES_MAX
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [3:0]  float_count,
  input  logic [3:0]  wide_int_count,
  input  logic [3:0]  narrow_int_count,
  input  logic [31:0] value_bits,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte,
  output logic        last_byte,
  output logic        status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tfb_pkg::*;

  localparam logic REG_SYNC = 1'b0;
  localparam logic REG_FUNC = 1'b1;

  logic [7:0] sync_byte;
  logic [7:0] function_id;
  logic       cfg_write;

  logic  accept;
  logic  job_push;
  job_t  job_in;
  job_t  job_out;
  logic  job_full;
  logic  job_empty;
  logic  job_pop;
  res_t  res_in;
  res_t  res_out;
  logic  res_push;
  logic  res_full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {24'h000000, (paddr[2] == REG_FUNC) ? function_id : sync_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte   <= TFB_SYNC_RESET;
      function_id <= TFB_FUNC_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SYNC) begin
        sync_byte <= pwdata[7:0];
      end else begin
        function_id <= pwdata[7:0];
      end
    end
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  tfb_front #(
    .FRAME_BYTES_MAX(FRAME_BYTES_MAX)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .action           (action),
    .float_count      (float_count),
    .wide_int_count   (wide_int_count),
    .narrow_int_count (narrow_int_count),
    .value_bits       (value_bits),
    .sync_byte        (sync_byte),
    .function_id      (function_id),
    .job_push         (job_push),
    .job              (job_in)
  );

  tfb_fifo #(
    .item_t (job_t),
    .DEPTH  (TFB_JOB_Q_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  tfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res       (res_in),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  tfb_fifo #(
    .item_t (res_t),
    .DEPTH  (TFB_RES_Q_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign frame_byte = res_out.frame_byte;
  assign last_byte  = res_out.last_byte;
  assign status     = res_out.status;

endmodule
